// ===== sv/sorted_run_merge_assert.svh =====
// ----------------------------------------------------------------------------
// sorted_run_merge_assert.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SORTED_RUN_MERGE_ASSERT_SVH
`define SORTED_RUN_MERGE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SRM_AST_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_run_merge check failed");

// next-cycle implication, disabled during reset
`define SRM_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_run_merge check failed");

`endif

// ===== sv/srm_pkg.sv =====
// ----------------------------------------------------------------------------
// srm_pkg
// Sizes and types shared by the sorted run merge block and its checker.
// ----------------------------------------------------------------------------
package srm_pkg;

	localparam int DEPTH  = 64;
	localparam int ELEM_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [ADDR_W:0]          bound_t;  // can hold DEPTH itself

endpackage

// ===== sv/sorted_run_merge.sv =====
// ----------------------------------------------------------------------------
// sorted_run_merge
// Stable two-way merge of adjacent sorted runs held in an on-chip store.
// ----------------------------------------------------------------------------
// Write: no result. Bad merge range: one error beat in the cycle after accept.
// Merge of n elements: first beat registered from the MERGE state, then one beat
// per cycle (one compare per cycle against the two store read ports), then
// copy-back of all n elements from the buffer before busy drops.
// arst_n clears control and the result strobe; both memories hold garbage
// until written. Results cannot be stalled by the receiver.
module sorted_run_merge (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    action,
	input  logic [5:0]              index,
	input  logic signed [31:0]      value,
	input  logic [5:0]              left_start,
	input  logic [6:0]              right_start,
	input  logic [5:0]              right_end,
	output logic                    strobe,
	output logic signed [31:0]      merged_value,
	output logic                    last,
	output logic                    error
);

	// sequencer codes
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MERGE = 2'd1;
	localparam logic [1:0] ST_COPY  = 2'd2;

	localparam srm_pkg::bound_t DEPTH_B = srm_pkg::bound_t'(srm_pkg::DEPTH);

	logic [1:0] state_q;

	// run bounds of the merge in flight
	srm_pkg::bound_t l_q, r_q, rs_q;
	srm_pkg::addr_t  pos_q, ls_q, re_q;

	srm_pkg::bound_t l_nx, r_nx;
	srm_pkg::addr_t  pos_nx;

	// element store: two read ports (left head, right head), one write port
	srm_pkg::elem_t store_mem [srm_pkg::DEPTH];
	srm_pkg::elem_t head_l_q, head_r_q;
	logic           st_we;
	srm_pkg::addr_t st_wa;
	srm_pkg::elem_t st_wd;

	// merge buffer: one read, one write
	srm_pkg::elem_t buf_mem [srm_pkg::DEPTH];
	srm_pkg::elem_t buf_rd_q;
	logic           buf_we;

	// forward for a buffer read that hits the entry written in the same cycle
	logic           fwd_q;
	srm_pkg::elem_t fwd_val_q;
	srm_pkg::elem_t copy_val;

	logic           acc, acc_merge, range_ok;
	logic           l_left, r_left, take_left;
	srm_pkg::elem_t pick;

	logic           strobe_q, last_q, error_q;
	srm_pkg::elem_t merged_q;

	assign busy      = (state_q != ST_IDLE);
	assign acc       = start && !busy;
	assign acc_merge = acc && action;

	// legal: left_start <= right_start <= right_end + 1, left_start <= right_end < DEPTH
	assign range_ok = ({1'b0, right_end} < DEPTH_B) && (left_start <= right_end)
		&& ({1'b0, left_start} <= right_start)
		&& (right_start <= ({1'b0, right_end} + 7'd1));

	// head selection; ties go left for stability
	assign l_left    = (l_q < rs_q);
	assign r_left    = (r_q <= {1'b0, re_q});
	assign take_left = (l_left && r_left) ? (head_l_q <= head_r_q) : l_left;
	assign pick      = take_left ? head_l_q : head_r_q;

	// next read pointers, presented to the memories so data lands with the state
	always_comb begin
		l_nx   = l_q;
		r_nx   = r_q;
		pos_nx = pos_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_merge) begin
					l_nx   = {1'b0, left_start};
					r_nx   = right_start;
					pos_nx = left_start;
				end
			end
			ST_MERGE: begin
				if (take_left) begin
					l_nx = l_q + 7'd1;
				end else begin
					r_nx = r_q + 7'd1;
				end
				pos_nx = (pos_q == re_q) ? ls_q : pos_q + 6'd1;
			end
			ST_COPY: begin
				pos_nx = pos_q + 6'd1;
			end
			default: begin
			end
		endcase
	end

	// store write: a write action while idle, or copy-back
	assign copy_val = fwd_q ? fwd_val_q : buf_rd_q;
	always_comb begin
		if (state_q == ST_COPY) begin
			st_we = 1'b1;
			st_wa = pos_q;
			st_wd = copy_val;
		end else begin
			st_we = acc && !action && ({1'b0, index} < DEPTH_B);
			st_wa = index;
			st_wd = value;
		end
	end

	assign buf_we = (state_q == ST_MERGE);

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_wa] <= st_wd;
		end
		head_l_q <= store_mem[l_nx[srm_pkg::ADDR_W-1:0]];
		head_r_q <= store_mem[r_nx[srm_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_mem[pos_q] <= pick;
		end
		buf_rd_q  <= buf_mem[pos_nx];
		fwd_val_q <= pick;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fwd_q   <= 1'b0;
		end else begin
			// single-element merge: copy reads the entry written this cycle
			fwd_q <= buf_we && (pos_nx == pos_q);
			unique case (state_q)
				ST_IDLE: begin
					if (acc_merge && range_ok) begin
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (pos_q == re_q) begin
						state_q <= ST_COPY;
					end
				end
				ST_COPY: begin
					if (pos_q == re_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		l_q   <= l_nx;
		r_q   <= r_nx;
		pos_q <= pos_nx;
		if (acc_merge) begin
			ls_q <= left_start;
			rs_q <= right_start;
			re_q <= right_end;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (acc_merge && !range_ok) || (state_q == ST_MERGE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MERGE) begin
			merged_q <= pick;
			last_q   <= (pos_q == re_q);
			error_q  <= 1'b0;
		end else begin
			merged_q <= '0;
			last_q   <= 1'b1;
			error_q  <= 1'b1;
		end
	end

	assign strobe       = strobe_q;
	assign merged_value = merged_q;
	assign last         = last_q;
	assign error        = error_q;

endmodule

// ===== sv/srm_checker.sv =====
// ----------------------------------------------------------------------------
// srm_checker
// Port-level checks on the sorted run merge block, bound into sorted_run_merge.
// ----------------------------------------------------------------------------
`include "sorted_run_merge_assert.svh"

module srm_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    action,
	input logic                    strobe,
	input logic signed [31:0]      merged_value,
	input logic                    last,
	input logic                    error
);

	srm_pkg::elem_t mv;
	assign mv = srm_pkg::elem_t'(merged_value);

	// error beat is a lone, zero-valued final beat
	`SRM_AST_NOW(a_err_shape, strobe && error, last && (mv == '0))
	// error beat comes in the cycle after a merge accept
	`SRM_AST_NOW(a_err_cause, strobe && error, $past(start && !busy && action))
	// merged beats only come out while the block is busy
	`SRM_AST_NOW(a_data_busy, strobe && !error, busy)
	// a write beat produces no result
	`SRM_AST_NXT(a_write_quiet, start && !busy && !action, !strobe)

endmodule

bind sorted_run_merge srm_checker u_srm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.action       (action),
	.strobe       (strobe),
	.merged_value (merged_value),
	.last         (last),
	.error        (error)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_run_merge. A shadow copy of the element store
// predicts each beat not typed into the table. Stimulus is a short directed table,
// then random write/merge traffic built mostly from sorted runs, with random sender gaps.
// ----------------------------------------------------------------------------
module testbench;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_MERGE = 1'b1
	} action_t;

	// one result beat as the block should present it
	typedef struct {
		srm_pkg::elem_t element;
		logic           is_last;
		logic           is_error;
	} merge_beat_t;

	// directed stimulus; pin = 1 means the single beat is typed in here
	typedef struct {
		action_t         act;
		srm_pkg::addr_t  idx;
		srm_pkg::elem_t  val;
		srm_pkg::addr_t  ls;
		srm_pkg::bound_t rs;
		srm_pkg::addr_t  re;
		bit              pin;
		srm_pkg::elem_t  exp_val;
		logic            exp_last;
		logic            exp_err;
	} plan_row_t;

	localparam int RANDOM_ITEMS = 500;
	localparam int QUIET_LIMIT  = 3000;  // covers the longest merge plus a long gap
	localparam int PLAN_LEN     = 19;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	logic         action;
	logic [5:0]   index;
	logic signed [31:0] value;
	logic [5:0]   left_start;
	logic [6:0]   right_start;
	logic [5:0]   right_end;
	logic         strobe;
	logic signed [31:0] merged_value;
	logic         last;
	logic         error;

	sorted_run_merge uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.index        (index),
		.value        (value),
		.left_start   (left_start),
		.right_start  (right_start),
		.right_end    (right_end),
		.strobe       (strobe),
		.merged_value (merged_value),
		.last         (last),
		.error        (error)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// shadow of the block's store, and what it still owes us
	srm_pkg::elem_t shadow_store [srm_pkg::DEPTH];
	bit             shadow_written [srm_pkg::DEPTH];
	merge_beat_t    merge_results_due [$];

	int          fail_count  = 0;
	int          items_sent  = 0;
	int          quiet_count = 0;
	bit          calm        = 1'b0;  // stretch with no sender gaps
	bit          pinned      = 1'b0;  // current beat's result comes from the table
	merge_beat_t pinned_beat;

	// directed part: extremes, empty runs, ties, every malformed shape
	plan_row_t plan [PLAN_LEN] = '{
		'{ACT_WRITE, 6'd0,  32'sh8000_0000, 6'd0,  7'd0,   6'd0,  1'b0, 32'sd0, 1'b0, 1'b0},
		'{ACT_WRITE, 6'd63, 32'sh7fff_ffff, 6'd0,  7'd0,   6'd0,  1'b0, 32'sd0, 1'b0, 1'b0},
		// right run empty, right_start at DEPTH
		'{ACT_MERGE, 6'd0,  32'sd0,         6'd63, 7'd64,  6'd63,
			1'b1, 32'sh7fff_ffff, 1'b1, 1'b0},
		// left run empty
		'{ACT_MERGE, 6'd0,  32'sd0,         6'd0,  7'd0,   6'd0,
			1'b1, 32'sh8000_0000, 1'b1, 1'b0},
		'{ACT_WRITE, 6'd1,  -32'sd5,        6'd0,  7'd0,   6'd0,  1'b0, 32'sd0, 1'b0, 1'b0},
		'{ACT_WRITE, 6'd2,  32'sd7,         6'd0,  7'd0,   6'd0,  1'b0, 32'sd0, 1'b0, 1'b0},
		'{ACT_WRITE, 6'd3,  -32'sd5,        6'd0,  7'd0,   6'd0,  1'b0, 32'sd0, 1'b0, 1'b0},
		'{ACT_WRITE, 6'd4,  32'sd100,       6'd0,  7'd0,   6'd0,  1'b0, 32'sd0, 1'b0, 1'b0},
		// tie across the runs
		'{ACT_MERGE, 6'd0,  32'sd0,         6'd1,  7'd3,   6'd4,  1'b0, 32'sd0, 1'b0, 1'b0},
		'{ACT_MERGE, 6'd0,  32'sd0,         6'd0,  7'd1,   6'd4,  1'b0, 32'sd0, 1'b0, 1'b0},
		// malformed: left_start past right_end
		'{ACT_MERGE, 6'd0,  32'sd0,         6'd5,  7'd5,   6'd4,  1'b1, 32'sd0, 1'b1, 1'b1},
		// malformed: right_start beyond right_end + 1
		'{ACT_MERGE, 6'd0,  32'sd0,         6'd0,  7'd10,  6'd5,  1'b1, 32'sd0, 1'b1, 1'b1},
		// malformed: right_start below left_start
		'{ACT_MERGE, 6'd0,  32'sd0,         6'd4,  7'd3,   6'd5,  1'b1, 32'sd0, 1'b1, 1'b1},
		// malformed: right_start at its field maximum
		'{ACT_MERGE, 6'd0,  32'sd0,         6'd0,  7'd127, 6'd63, 1'b1, 32'sd0, 1'b1, 1'b1},
		'{ACT_WRITE, 6'd62, 32'sd0,         6'd0,  7'd0,   6'd0,  1'b0, 32'sd0, 1'b0, 1'b0},
		'{ACT_MERGE, 6'd0,  32'sd0,         6'd62, 7'd63,  6'd63, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{ACT_MERGE, 6'd0,  32'sd0,         6'd62, 7'd62,  6'd63, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{ACT_WRITE, 6'd5,  -32'sd1,        6'd0,  7'd0,   6'd0,  1'b0, 32'sd0, 1'b0, 1'b0},
		// right run not sorted: walked all the same
		'{ACT_MERGE, 6'd0,  32'sd0,         6'd0,  7'd3,   6'd5,  1'b0, 32'sd0, 1'b0, 1'b0}
	};

	function automatic bit range_is_legal(int ls, int rs, int re);
		return re < srm_pkg::DEPTH && ls <= re && ls <= rs && rs <= re + 1;
	endfunction

	// Applies one accepted item to the shadow store and queues the beats it owes.
	function automatic void predict_store_action(action_t act, srm_pkg::addr_t idx,
			srm_pkg::elem_t val, srm_pkg::addr_t ls, srm_pkg::bound_t rs,
			srm_pkg::addr_t re);
		srm_pkg::elem_t scratch [srm_pkg::DEPTH];
		int             l;
		int             r;
		bit             take_left;

		if (act == ACT_WRITE) begin
			shadow_store[idx]   = val;
			shadow_written[idx] = 1'b1;
			return;
		end
		if (!range_is_legal(ls, rs, re)) begin
			merge_results_due.push_back('{32'sd0, 1'b1, 1'b1});
			return;
		end
		l = ls;
		r = rs;
		for (int p = ls; p <= re; p++) begin
			// stable: left wins a tie; once a run runs dry the other is copied
			if (l < rs && r <= re)
				take_left = shadow_store[l] <= shadow_store[r];
			else
				take_left = l < rs;
			if (take_left) begin
				scratch[p] = shadow_store[l];
				l++;
			end else begin
				scratch[p] = shadow_store[r];
				r++;
			end
		end
		for (int p = ls; p <= re; p++) begin
			shadow_store[p] = scratch[p];
			merge_results_due.push_back('{scratch[p], logic'(p == re), 1'b0});
		end
	endfunction

	// Presents one item from a falling edge and holds it until a rising edge
	// finds busy low. A random gap, with the fields scrambled, goes first.
	task automatic send(action_t act, srm_pkg::addr_t idx, srm_pkg::elem_t val,
			srm_pkg::addr_t ls, srm_pkg::bound_t rs, srm_pkg::addr_t re);
		int roll;
		int gap;

		roll = $urandom_range(0, 99);
		if (calm || roll < 50)
			gap = 0;
		else if (roll < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		@(negedge clk);
		if (gap > 0) begin
			start       = 1'b0;
			action      = 1'($urandom_range(0, 1));
			index       = 6'($urandom);
			value       = 32'($urandom);
			left_start  = 6'($urandom);
			right_start = 7'($urandom);
			right_end   = 6'($urandom);
			repeat (gap) @(negedge clk);
		end
		start       = 1'b1;
		action      = act;
		index       = idx;
		value       = val;
		left_start  = ls;
		right_start = rs;
		right_end   = re;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
	endtask

	// Writes count non-decreasing values from first on. A crowded run starts near
	// zero and steps by zero or one so that ties across the two runs are common.
	task automatic write_sorted_run(int first, int count, bit crowded);
		longint level;

		if (crowded)
			level = longint'($urandom_range(0, 6)) - 3;
		else
			level = longint'($signed($urandom));
		for (int k = 0; k < count; k++) begin
			if (crowded)
				level += $urandom_range(0, 1);
			else
				level += $urandom_range(0, 32'h0400_0000);
			if (level > 64'sd2147483647)
				level = 64'sd2147483647;
			send(ACT_WRITE, srm_pkg::addr_t'(first + k), srm_pkg::elem_t'(level),
				6'd0, 7'd0, 6'd0);
		end
	endtask

	// Result checking, item capture for the predictor and the watchdog all sit
	// on the rising edge, so they see the values from before the edge.
	always @(posedge clk) begin : monitor
		merge_beat_t want;
		bit          moved;

		if (arst_n) begin
			moved = strobe || (start && !busy);
			if (strobe) begin
				if (merge_results_due.size() == 0) begin
					$display("%0t: beat with nothing due: merged_value %0d last %b error %b",
						$time, merged_value, last, error);
					fail_count++;
				end else begin
					want = merge_results_due.pop_front();
					if (merged_value !== want.element) begin
						$display("%0t: merged_value expected %0d actual %0d",
							$time, want.element, merged_value);
						fail_count++;
					end
					if (last !== want.is_last) begin
						$display("%0t: last expected %b actual %b", $time, want.is_last, last);
						fail_count++;
					end
					if (error !== want.is_error) begin
						$display("%0t: error expected %b actual %b",
							$time, want.is_error, error);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				// typed-in rows leave the store as it was, so no shadow update
				if (pinned)
					merge_results_due.push_back(pinned_beat);
				else
					predict_store_action(action_t'(action), index, value,
						left_start, right_start, right_end);
			end
			quiet_count = moved ? 0 : quiet_count + 1;
			if (quiet_count >= QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int     roll;
		int     span;
		int     ls;
		int     rs;
		int     re;
		bit     filled;

		arst_n      = 1'b0;
		start       = 1'b0;
		action      = ACT_WRITE;
		index       = '0;
		value       = '0;
		left_start  = '0;
		right_start = '0;
		right_end   = '0;
		for (int i = 0; i < srm_pkg::DEPTH; i++) begin
			shadow_store[i]   = '0;
			shadow_written[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// the pin flag changes on the accept edge of the row before, so it only
		// lands once the monitor has taken that edge
		foreach (plan[i]) begin
			pinned      <= plan[i].pin;
			pinned_beat <= '{plan[i].exp_val, plan[i].exp_last, plan[i].exp_err};
			send(plan[i].act, plan[i].idx, plan[i].val, plan[i].ls, plan[i].rs, plan[i].re);
		end
		pinned <= 1'b0;

		while (items_sent < PLAN_LEN + RANDOM_ITEMS) begin
			if ($urandom_range(0, 29) == 0)
				calm = $urandom_range(0, 2) == 0;
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				// well-formed: two fresh sorted runs, then the merge over them
				roll = $urandom_range(0, 99);
				if (roll < 80)
					span = $urandom_range(1, 8);
				else if (roll < 95)
					span = $urandom_range(9, 24);
				else
					span = srm_pkg::DEPTH;
				ls = $urandom_range(0, srm_pkg::DEPTH - span);
				re = ls + span - 1;
				rs = $urandom_range(ls, re + 1);
				filled = $urandom_range(0, 2) == 0;  // crowded runs
				write_sorted_run(ls, rs - ls, filled);
				write_sorted_run(rs, re + 1 - rs, filled);
				send(ACT_MERGE, srm_pkg::addr_t'($urandom), srm_pkg::elem_t'($urandom),
					srm_pkg::addr_t'(ls), srm_pkg::bound_t'(rs), srm_pkg::addr_t'(re));
			end else if (roll < 80) begin
				send(ACT_WRITE, srm_pkg::addr_t'($urandom), srm_pkg::elem_t'($urandom),
					srm_pkg::addr_t'($urandom), srm_pkg::bound_t'($urandom),
					srm_pkg::addr_t'($urandom));
			end else if (roll < 90) begin
				// merge over whatever is stored, sorted or not; never an unwritten entry
				ls = $urandom_range(0, srm_pkg::DEPTH - 1);
				re = $urandom_range(ls, srm_pkg::DEPTH - 1);
				rs = $urandom_range(ls, re + 1);
				filled = 1'b1;
				for (int i = ls; i <= re; i++)
					filled &= shadow_written[i];
				if (filled)
					send(ACT_MERGE, srm_pkg::addr_t'($urandom), srm_pkg::elem_t'($urandom),
						srm_pkg::addr_t'(ls), srm_pkg::bound_t'(rs), srm_pkg::addr_t'(re));
			end else begin
				// malformed range; a legal draw is pushed just out of bounds
				ls = $urandom_range(0, srm_pkg::DEPTH - 1);
				rs = $urandom_range(0, 127);
				re = $urandom_range(0, srm_pkg::DEPTH - 1);
				if (range_is_legal(ls, rs, re))
					rs = re + 2;
				send(ACT_MERGE, srm_pkg::addr_t'($urandom), srm_pkg::elem_t'($urandom),
					srm_pkg::addr_t'(ls), srm_pkg::bound_t'(rs), srm_pkg::addr_t'(re));
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (merge_results_due.size() != 0)
			@(posedge clk);
		// copy-back after the last beat, plus margin for any stray beat
		repeat (2 * srm_pkg::DEPTH + 8) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
